// ----- hw/rtl/ssc_pkg.sv -----
package ssc_pkg;

  localparam int unsigned LANE_W       = 32;
  localparam int unsigned NUM_LANES    = 4;
  localparam int unsigned CODE_W       = 4;
  localparam int unsigned META_W       = 32;
  localparam int unsigned META_INDEX_W = 21;
  localparam int unsigned ROWS_W       = 13;
  localparam int unsigned COLS_W       = 13;
  localparam int unsigned MAG_W        = 31;
  localparam int unsigned SLOT_W       = 3;
  localparam int unsigned PADDR_W      = 4;
  localparam int unsigned PDATA_W      = 32;

  typedef enum logic [1:0] {
    ET_INT8 = 2'd0,
    ET_FP16 = 2'd1,
    ET_BF16 = 2'd2,
    ET_FP32 = 2'd3
  } elem_type_t;

  localparam logic [1:0] REG_ELEMENT_TYPE = 2'd0;
  localparam logic [1:0] REG_MATRIX_ROWS  = 2'd1;
  localparam logic [1:0] REG_MATRIX_COLS  = 2'd2;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd32;
  localparam logic [COLS_W-1:0] COLS_RESET = 13'd64;

  localparam logic [CODE_W-1:0] CODE_FP32_LANE0 = 4'd4;
  localparam logic [CODE_W-1:0] CODE_FP32_LANE1 = 4'd14;

  localparam logic [MAG_W-1:0] FP16_INF = 31'h0000_7C00;
  localparam logic [MAG_W-1:0] BF16_INF = 31'h0000_7F80;
  localparam logic [MAG_W-1:0] FP32_INF = 31'h7F80_0000;

  typedef struct packed {
    elem_type_t          element_type;
    logic [ROWS_W-1:0]   matrix_rows;
    logic [COLS_W-1:0]   matrix_cols;
  } cfg_t;

  typedef struct packed {
    logic [LANE_W-1:0] lane0;
    logic [LANE_W-1:0] lane1;
    logic [LANE_W-1:0] lane2;
    logic [LANE_W-1:0] lane3;
  } in_item_t;

  typedef struct packed {
    logic [LANE_W-1:0]       kept_first;
    logic [LANE_W-1:0]       kept_second;
    logic [CODE_W-1:0]       group_code;
    logic                    meta_ready;
    logic [META_W-1:0]       meta_word;
    logic [META_INDEX_W-1:0] meta_index;
  } out_item_t;

  typedef struct packed {
    logic                    ready;
    logic [META_W-1:0]       word;
    logic [META_INDEX_W-1:0] index;
  } meta_out_t;

endpackage

// ----- hw/rtl/ssc_cfg.sv -----
module ssc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssc_pkg::PADDR_W-1:0]  paddr,
  input  logic [ssc_pkg::PDATA_W-1:0]  pwdata,
  output logic [ssc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output ssc_pkg::cfg_t                cfg
);

  ssc_pkg::cfg_t cfg_r;
  ssc_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [1:0]    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        ssc_pkg::REG_ELEMENT_TYPE: begin
          cfg_nxt.element_type = ssc_pkg::elem_type_t'(pwdata[1:0]);
        end
        ssc_pkg::REG_MATRIX_ROWS: begin
          cfg_nxt.matrix_rows = pwdata[ssc_pkg::ROWS_W-1:0];
        end
        ssc_pkg::REG_MATRIX_COLS: begin
          cfg_nxt.matrix_cols = pwdata[ssc_pkg::COLS_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ssc_pkg::REG_ELEMENT_TYPE: begin
        prdata = {30'b0, cfg_r.element_type};
      end
      ssc_pkg::REG_MATRIX_ROWS: begin
        prdata = {19'b0, cfg_r.matrix_rows};
      end
      ssc_pkg::REG_MATRIX_COLS: begin
        prdata = {19'b0, cfg_r.matrix_cols};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.element_type <= ssc_pkg::ET_INT8;
      cfg_r.matrix_rows  <= ssc_pkg::ROWS_RESET;
      cfg_r.matrix_cols  <= ssc_pkg::COLS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hw/rtl/ssc_select.sv -----
module ssc_select (
  input  ssc_pkg::elem_type_t              element_type,
  input  ssc_pkg::in_item_t                item,
  output logic [ssc_pkg::LANE_W-1:0]       kept_first,
  output logic [ssc_pkg::LANE_W-1:0]       kept_second,
  output logic [ssc_pkg::CODE_W-1:0]       group_code
);

  logic [3:0][ssc_pkg::LANE_W-1:0] lane;
  logic [3:0][ssc_pkg::MAG_W-1:0]  mag;
  logic [3:0]                      nan;
  logic [ssc_pkg::LANE_W-1:0]      elem_mask;
  logic                            four;
  logic [1:0]                      sel0;
  logic [1:0]                      sel1;
  logic [1:0]                      lo;
  logic [1:0]                      hi;

  // Scan in lane order; a NaN best is never replaced.
  function automatic logic [1:0] pick(
    input logic [3:0][ssc_pkg::MAG_W-1:0] m,
    input logic [3:0]                     n,
    input logic [3:0]                     used,
    input logic                           all4
  );
    logic [1:0] best;
    logic       found;
    best  = 2'd0;
    found = 1'b0;
    for (int p = 0; p < 4; p++) begin
      if ((all4 || p < 2) && !used[p]) begin
        if (!found || (!n[best] && !n[p] && m[p] > m[best])) begin
          best  = 2'(p);
          found = 1'b1;
        end
      end
    end
    return best;
  endfunction

  always_comb begin
    unique case (element_type)
      ssc_pkg::ET_INT8: elem_mask = 32'h0000_00FF;
      ssc_pkg::ET_FP32: elem_mask = 32'hFFFF_FFFF;
      default:          elem_mask = 32'h0000_FFFF;
    endcase
  end

  assign lane[0] = item.lane0 & elem_mask;
  assign lane[1] = item.lane1 & elem_mask;
  assign lane[2] = item.lane2 & elem_mask;
  assign lane[3] = item.lane3 & elem_mask;

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      unique case (element_type)
        ssc_pkg::ET_INT8: begin
          mag[p] = lane[p][7] ? 31'(9'h100 - {1'b0, lane[p][7:0]})
                              : 31'(lane[p][7:0]);
          nan[p] = 1'b0;
        end
        ssc_pkg::ET_FP16: begin
          mag[p] = 31'(lane[p][14:0]);
          nan[p] = mag[p] > ssc_pkg::FP16_INF;
        end
        ssc_pkg::ET_BF16: begin
          mag[p] = 31'(lane[p][14:0]);
          nan[p] = mag[p] > ssc_pkg::BF16_INF;
        end
        default: begin
          mag[p] = lane[p][30:0];
          nan[p] = mag[p] > ssc_pkg::FP32_INF;
        end
      endcase
    end
  end

  assign four = (element_type != ssc_pkg::ET_FP32);
  assign sel0 = pick(mag, nan, 4'b0000, four);
  assign sel1 = pick(mag, nan, 4'b0001 << sel0, four);
  assign lo   = (sel0 > sel1) ? sel1 : sel0;
  assign hi   = (sel0 > sel1) ? sel0 : sel1;

  always_comb begin
    if (four) begin
      kept_first  = lane[lo];
      kept_second = lane[hi];
      group_code  = {hi, lo};
    end else begin
      kept_first  = lane[sel0];
      kept_second = '0;
      group_code  = (sel0 == 2'd0) ? ssc_pkg::CODE_FP32_LANE0 : ssc_pkg::CODE_FP32_LANE1;
    end
  end

endmodule

// ----- hw/rtl/ssc_meta.sv -----
module ssc_meta #(
  parameter int unsigned MAX_ROWS = 4096,
  parameter int unsigned MAX_COLS = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ssc_pkg::cfg_t               cfg,
  input  logic                        step,
  input  logic [ssc_pkg::CODE_W-1:0]  code,
  output ssc_pkg::meta_out_t          meta
);

  localparam int unsigned RC_W = $clog2(MAX_ROWS);
  localparam int unsigned GC_W = $clog2(MAX_COLS / 8);
  localparam int unsigned IW   = ssc_pkg::META_INDEX_W;

  logic [RC_W-1:0]                row_r, row_nxt;
  logic [GC_W-1:0]                col_r, col_nxt;
  logic [ssc_pkg::SLOT_W-1:0]     slot_r, slot_nxt;
  logic [ssc_pkg::META_W-1:0]     acc_r, acc_nxt;

  logic                           int8;
  logic [ssc_pkg::ROWS_W-1:0]     rows_eff;
  logic [ssc_pkg::COLS_W-1:0]     cols_eff;
  logic [ssc_pkg::COLS_W-1:0]     mcols_raw;
  logic [ssc_pkg::COLS_W-1:0]     mcols;
  logic [ssc_pkg::META_W-1:0]     acc_with;
  logic [3:0]                     slot_inc;
  logic [3:0]                     gpm;
  logic                           word_done;
  logic [IW-1:0]                  row_ext;
  logic [IW-1:0]                  col_ext;
  logic [IW-1:0]                  dr;
  logic [IW-1:0]                  idx_linear;
  logic [IW-1:0]                  idx_inter;
  logic [IW-1:0]                  col_rows;
  logic                           interleave;

  assign int8 = (cfg.element_type == ssc_pkg::ET_INT8);

  always_comb begin
    if (cfg.matrix_rows == '0) begin
      rows_eff = 13'd1;
    end else if (32'(cfg.matrix_rows) > MAX_ROWS) begin
      rows_eff = ssc_pkg::ROWS_W'(MAX_ROWS);
    end else begin
      rows_eff = cfg.matrix_rows;
    end
    cols_eff = (32'(cfg.matrix_cols) > MAX_COLS) ? ssc_pkg::COLS_W'(MAX_COLS)
                                                 : cfg.matrix_cols;
  end

  // Group size times groups per word: 32 int8, 16 half types, 8 fp32.
  always_comb begin
    unique case (cfg.element_type)
      ssc_pkg::ET_INT8: mcols_raw = cols_eff >> 5;
      ssc_pkg::ET_FP32: mcols_raw = cols_eff >> 3;
      default:          mcols_raw = cols_eff >> 4;
    endcase
    mcols = (mcols_raw == '0) ? 13'd1 : mcols_raw;
  end

  assign acc_with  = acc_r | (32'(code) << {slot_r, 2'b00});
  assign slot_inc  = {1'b0, slot_r} + 4'd1;
  assign gpm       = int8 ? 4'd8 : 4'd4;
  assign word_done = (slot_inc >= gpm);

  assign row_ext = IW'(row_r);
  assign col_ext = IW'(col_r);

  always_comb begin
    if (int8) begin
      dr = {row_ext[IW-1:4], row_ext[2:0], row_ext[3]};
    end else begin
      dr = {row_ext[IW-1:5], row_ext[2:0], row_ext[4:3]};
    end
  end

  assign interleave = (int8 ? (rows_eff[3:0] == '0) : (rows_eff[4:0] == '0))
                      && !mcols[0];
  assign idx_linear = IW'(row_ext * mcols) + col_ext;
  assign col_rows   = IW'(col_ext[IW-1:1] * rows_eff);
  // Odd/even row pairs swap with odd/even column pairs.
  assign idx_inter  = {col_rows[IW-2:0], 1'b0} + {dr[IW-2:1], col_ext[0], dr[0]};

  always_comb begin
    meta.ready = word_done;
    meta.word  = '0;
    meta.index = '0;
    if (word_done) begin
      meta.word  = int8 ? acc_with : {16'b0, acc_with[15:0]};
      meta.index = interleave ? idx_inter : idx_linear;
    end
  end

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    slot_nxt = slot_r;
    acc_nxt  = acc_r;
    if (step) begin
      if (word_done) begin
        acc_nxt  = '0;
        slot_nxt = '0;
        if (IW'(col_ext + 1'b1) >= IW'(mcols)) begin
          col_nxt = '0;
          if (IW'(row_ext + 1'b1) >= IW'(rows_eff)) begin
            row_nxt = '0;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end else begin
        acc_nxt  = acc_with;
        slot_nxt = slot_inc[ssc_pkg::SLOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
      acc_r  <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // Nothing is packed at or above the current slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r >> {slot_r, 2'b00}) == '0)
    else $error("metadata accumulator holds bits beyond current slot");

endmodule

// ----- hw/rtl/structured_sparse_compressor.sv -----
// Each input passes through the input register, then the result register, before its result
// can be transferred; out_valid rises once the result register is loaded.
// Throughput: one group per cycle while out_ready is high; with out_ready low the
// two registers fill after two groups and in_ready drops until out_ready returns.
// Reset (rst_n low, synchronous): pipeline empty, counters and metadata
// accumulator zero, element_type int8, matrix_rows 32, matrix_cols 64.
module structured_sparse_compressor #(
  parameter int unsigned MAX_ROWS = 4096,
  parameter int unsigned MAX_COLS = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ssc_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ssc_pkg::out_item_t           out_payload,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssc_pkg::PADDR_W-1:0]  paddr,
  input  logic [ssc_pkg::PDATA_W-1:0]  pwdata,
  output logic [ssc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  ssc_pkg::cfg_t             cfg;
  logic                      s1_valid_r, s1_valid_nxt;
  ssc_pkg::in_item_t         s1_data_r;
  logic                      out_valid_r, out_valid_nxt;
  ssc_pkg::out_item_t        out_payload_r;
  ssc_pkg::out_item_t        result;
  ssc_pkg::meta_out_t        meta;
  logic                      advance;
  logic                      in_xfer;
  logic [ssc_pkg::LANE_W-1:0] kept_first;
  logic [ssc_pkg::LANE_W-1:0] kept_second;
  logic [ssc_pkg::CODE_W-1:0] group_code;

  ssc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssc_select u_select (
    .element_type (cfg.element_type),
    .item         (s1_data_r),
    .kept_first   (kept_first),
    .kept_second  (kept_second),
    .group_code   (group_code)
  );

  ssc_meta #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_meta (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (advance),
    .code  (group_code),
    .meta  (meta)
  );

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    result.kept_first  = kept_first;
    result.kept_second = kept_second;
    result.group_code  = group_code;
    result.meta_ready  = meta.ready;
    result.meta_word   = meta.word;
    result.meta_index  = meta.index;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_payload_r <= result;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.meta_ready |->
      out_payload.meta_word == '0 && out_payload.meta_index == '0)
    else $error("metadata word or index set without a completed word");

  assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded after stage advance");

  assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled while input register is empty");

endmodule
